@@ rtl/url_percent_decoder_macros.svh @@
// Assertion macros for the URL percent decoder.
// Included by url_percent_decoder.sv; expects clk and rst_n in scope.
`ifndef URL_PERCENT_DECODER_MACROS_SVH
`define URL_PERCENT_DECODER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define UPD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define UPD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/upd_pkg.sv @@
// Shared types, constants and helper functions for the URL percent decoder.
// No dependencies; used by all rtl modules through scoped names.
`timescale 1ns / 1ps

package upd_pkg;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_PCT   = 8'h25;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CTRL_LIMIT = 8'd32;
    localparam logic [7:0] CHAR_DEL   = 8'd127;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_PCT,
        MODE_DIG,
        MODE_DROP
    } mode_t;

    typedef enum logic [1:0] {
        TAIL_NONE,
        TAIL_BYTE,
        TAIL_END,
        TAIL_FORB
    } tail_t;

    // Work for the back end: optional literal '%', optional held digit, then a tail.
    typedef struct packed {
        logic       emit_pct;
        logic       emit_held;
        logic [7:0] held_char;
        tail_t      tail;
        logic [7:0] tail_char;
    } job_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       char_valid;
        logic       string_end;
        logic       forbidden;
        logic       run_last;
    } res_t;

    function automatic logic is_hex(input logic [7:0] c);
        is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
                 (c >= 8'h41 && c <= 8'h46);
    endfunction

    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        logic [7:0] v;
        v = 8'h00;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            v = c - 8'h30;
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            v = c - 8'h57;
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            v = c - 8'h37;
        end
        hex_nibble = v[3:0];
    endfunction

endpackage

@@ rtl/upd_front.sv @@
// Front end: accepts bytes, tracks escapes, emits at most one job per byte.
// Depends on upd_pkg.
`timescale 1ns / 1ps

module upd_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  logic [7:0]      in_char,
    output logic            job_push,
    output upd_pkg::job_t   job
);

    upd_pkg::mode_t mode_reg;
    upd_pkg::mode_t mode_next;
    logic [7:0]     held_reg;
    logic [7:0]     held_next;

    logic           c_hex;
    logic [7:0]     dec_val;
    logic           dec_bad;

    assign c_hex   = upd_pkg::is_hex(in_char);
    assign dec_val = {upd_pkg::hex_nibble(held_reg), upd_pkg::hex_nibble(in_char)};
    assign dec_bad = (dec_val < upd_pkg::CTRL_LIMIT) || (dec_val == upd_pkg::CHAR_DEL);

    // next state
    always_comb
    begin
        mode_next = mode_reg;
        held_next = held_reg;
        if (accept)
        begin
            unique case (mode_reg)
                upd_pkg::MODE_IDLE:
                begin
                    mode_next = (in_char == upd_pkg::CHAR_PCT) ? upd_pkg::MODE_PCT
                                                               : upd_pkg::MODE_IDLE;
                end
                upd_pkg::MODE_PCT:
                begin
                    if (c_hex)
                    begin
                        held_next = in_char;
                        mode_next = upd_pkg::MODE_DIG;
                    end
                    else
                    begin
                        mode_next = (in_char == upd_pkg::CHAR_PCT) ? upd_pkg::MODE_PCT
                                                                   : upd_pkg::MODE_IDLE;
                    end
                end
                upd_pkg::MODE_DIG:
                begin
                    if (c_hex)
                    begin
                        mode_next = dec_bad ? upd_pkg::MODE_DROP : upd_pkg::MODE_IDLE;
                    end
                    else
                    begin
                        mode_next = (in_char == upd_pkg::CHAR_PCT) ? upd_pkg::MODE_PCT
                                                                   : upd_pkg::MODE_IDLE;
                    end
                end
                upd_pkg::MODE_DROP:
                begin
                    if (in_char == upd_pkg::CHAR_NUL)
                    begin
                        mode_next = upd_pkg::MODE_IDLE;
                    end
                end
                default:
                begin
                    mode_next = upd_pkg::MODE_IDLE;
                end
            endcase
        end
    end

    // job outputs
    always_comb
    begin
        upd_pkg::job_t j;
        upd_pkg::tail_t plain_tail;
        logic [7:0]     plain_char;

        plain_char = in_char;
        priority if (in_char == upd_pkg::CHAR_NUL)
        begin
            plain_tail = upd_pkg::TAIL_END;
            plain_char = upd_pkg::CHAR_NUL;
        end
        else if (in_char == upd_pkg::CHAR_PCT)
        begin
            plain_tail = upd_pkg::TAIL_NONE;
        end
        else if (in_char == upd_pkg::CHAR_PLUS)
        begin
            plain_tail = upd_pkg::TAIL_BYTE;
            plain_char = upd_pkg::CHAR_SPACE;
        end
        else
        begin
            plain_tail = upd_pkg::TAIL_BYTE;
        end

        j.emit_pct  = 1'b0;
        j.emit_held = 1'b0;
        j.held_char = held_reg;
        j.tail      = upd_pkg::TAIL_NONE;
        j.tail_char = plain_char;

        unique case (mode_reg)
            upd_pkg::MODE_IDLE:
            begin
                j.tail = plain_tail;
            end
            upd_pkg::MODE_PCT:
            begin
                if (!c_hex)
                begin
                    j.emit_pct = 1'b1;
                    j.tail     = plain_tail;
                end
            end
            upd_pkg::MODE_DIG:
            begin
                if (c_hex)
                begin
                    j.tail      = dec_bad ? upd_pkg::TAIL_FORB : upd_pkg::TAIL_BYTE;
                    j.tail_char = dec_val;
                end
                else
                begin
                    j.emit_pct  = 1'b1;
                    j.emit_held = 1'b1;
                    j.tail      = plain_tail;
                end
            end
            upd_pkg::MODE_DROP:
            begin
                j.tail      = (in_char == upd_pkg::CHAR_NUL) ? upd_pkg::TAIL_END
                                                             : upd_pkg::TAIL_NONE;
                j.tail_char = upd_pkg::CHAR_NUL;
            end
            default:
            begin
                j.tail = upd_pkg::TAIL_NONE;
            end
        endcase

        job      = j;
        job_push = accept && (j.emit_pct || (j.tail != upd_pkg::TAIL_NONE));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= upd_pkg::MODE_IDLE;
            held_reg <= 8'h00;
        end
        else
        begin
            mode_reg <= mode_next;
            held_reg <= held_next;
        end
    end

endmodule

@@ rtl/upd_fifo.sv @@
// Short job queue between front and back end.
// Depends on upd_pkg.
`timescale 1ns / 1ps

module upd_fifo
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  upd_pkg::job_t   din,
    output logic            full,
    input  logic            pop,
    output upd_pkg::job_t   dout,
    output logic            empty
);

    upd_pkg::job_t                  mem_reg [upd_pkg::FIFO_DEPTH];
    logic [upd_pkg::FIFO_AW-1:0]    wr_ptr_reg;
    logic [upd_pkg::FIFO_AW-1:0]    rd_ptr_reg;
    logic [upd_pkg::FIFO_AW:0]      count_reg;
    logic                           do_push;
    logic                           do_pop;

    assign full    = (count_reg == (upd_pkg::FIFO_AW + 1)'(upd_pkg::FIFO_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

@@ rtl/upd_back.sv @@
// Back end: expands each job into one to three result beats into an output register.
// Depends on upd_pkg.
`timescale 1ns / 1ps

module upd_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  upd_pkg::job_t   job,
    input  logic            job_empty,
    output logic            job_pop,
    output upd_pkg::res_t   res,
    output logic            res_valid,
    input  logic            res_pop
);

    logic [1:0]     step_reg;
    logic [1:0]     step_next;
    logic           out_valid_reg;
    upd_pkg::res_t  out_reg;
    upd_pkg::res_t  cur;
    logic [1:0]     lead;
    logic [1:0]     total;
    logic           is_last;
    logic           advance;

    assign lead    = {1'b0, job.emit_pct} + {1'b0, job.emit_held};
    assign total   = lead + {1'b0, job.tail != upd_pkg::TAIL_NONE};
    assign is_last = (step_reg == total - 2'd1);
    assign advance = !job_empty && (!out_valid_reg || res_pop);
    assign job_pop = advance && is_last;

    always_comb
    begin
        cur            = '0;
        cur.run_last   = is_last;
        if (step_reg < lead)
        begin
            cur.char_valid = 1'b1;
            cur.out_char   = (step_reg == 2'd0) ? upd_pkg::CHAR_PCT : job.held_char;
        end
        else
        begin
            unique case (job.tail)
                upd_pkg::TAIL_BYTE:
                begin
                    cur.char_valid = 1'b1;
                    cur.out_char   = job.tail_char;
                end
                upd_pkg::TAIL_END:
                begin
                    cur.string_end = 1'b1;
                end
                upd_pkg::TAIL_FORB:
                begin
                    cur.forbidden = 1'b1;
                end
                default:
                begin
                    cur.char_valid = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        step_next = step_reg;
        if (advance)
        begin
            step_next = is_last ? 2'd0 : step_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign res       = out_reg;
    assign res_valid = out_valid_reg;

endmodule

@@ rtl/url_percent_decoder.sv @@
// Streaming URL percent decoder, top level.
// Depends on upd_pkg, upd_front, upd_fifo, upd_back, url_percent_decoder_macros.svh.
//
// Input side is a queue write port: a byte beat is taken on a clock edge with
// push high and full low. A zero byte ends the string.
// Result side is a queue read port: while empty is low the oldest result beat is
// on out_char/char_valid/string_end/forbidden/run_last; pop takes it.
// Each result beat is exactly one of a byte, an end marker or a forbidden report;
// run_last marks the last beat caused by one input byte.
// A result passes through the job queue and then the result register.
// Throughput while pop takes every result: one byte per cycle while each byte causes
// at most one result; a broken escape expands into up to three results, one per
// cycle from the expansion stage. A four-entry job queue separates the two sides.
// Reset clears the escape state, the job queue and the result valid flag.
// When pop stays low the result stays put, the queue fills, and full rises.
`timescale 1ns / 1ps

`include "url_percent_decoder_macros.svh"

module url_percent_decoder
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  in_char,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  out_char,
    output logic        char_valid,
    output logic        string_end,
    output logic        forbidden,
    output logic        run_last
);

    logic           accept;
    logic           job_push;
    logic           job_full;
    logic           job_pop;
    logic           job_empty;
    upd_pkg::job_t  job_in;
    upd_pkg::job_t  job_head;
    upd_pkg::res_t  res;
    logic           res_valid;

    assign full   = job_full;
    assign accept = push && !job_full;

    upd_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .in_char  (in_char),
        .job_push (job_push),
        .job      (job_in)
    );

    upd_fifo u_fifo
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (job_push),
        .din   (job_in),
        .full  (job_full),
        .pop   (job_pop),
        .dout  (job_head),
        .empty (job_empty)
    );

    upd_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (job_head),
        .job_empty (job_empty),
        .job_pop   (job_pop),
        .res       (res),
        .res_valid (res_valid),
        .res_pop   (pop)
    );

    assign empty      = !res_valid;
    assign out_char   = res.out_char;
    assign char_valid = res.char_valid;
    assign string_end = res.string_end;
    assign forbidden  = res.forbidden;
    assign run_last   = res.run_last;

    `UPD_ASSERT_NOW(a_one_kind, !empty, $onehot({char_valid, string_end, forbidden}), "result beat must be exactly one kind")
    `UPD_ASSERT_NOW(a_tail_last, !empty && (string_end || forbidden), run_last, "end or forbidden beat must close its run")
    `UPD_ASSERT_NOW(a_zero_char, !empty && !char_valid, out_char == 8'h00, "non-byte beat must carry zero")
    `UPD_ASSERT_NOW(a_no_overflow, job_push, !job_full, "job pushed into a full queue")

endmodule
